FILE: rtl/cbz_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and helpers for the cubic Bezier point generator.
// No dependencies.
package cbz_pkg;

  localparam int COORD_W  = 16;  // coordinate width
  localparam int COEF_W   = 21;  // polynomial coefficient width
  localparam int HORN_W   = 22;  // Horner accumulator width
  localparam int TFRAC    = 16;  // fraction bits of t
  localparam int T_W      = TFRAC + 1;          // t in Q1.16, up to 1.0
  localparam int PROD_W   = HORN_W + T_W + 1;   // signed product width
  localparam int CNT_W    = 7;   // point_count width
  localparam int IDX_W    = 6;   // point index width
  localparam int MAX_PTS  = 64;
  localparam int DIV_W    = TFRAC + 2;          // dividend 2^(TFRAC+1)
  localparam int DVS_W    = 7;   // divisor 2*(N-1), at most 126

  // Clamp a Horner result to the coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [HORN_W-1:0] v);
    logic signed [HORN_W-1:0] hi;
    logic signed [HORN_W-1:0] lo;
    begin
      hi = HORN_W'((1 << (COORD_W - 1)) - 1);
      lo = -HORN_W'(1 << (COORD_W - 1));
      if (v > hi) sat_coord = hi[COORD_W-1:0];
      else if (v < lo) sat_coord = lo[COORD_W-1:0];
      else sat_coord = v[COORD_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/cbz_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for control-point input and curve-point output.
// Depends on cbz_pkg for field widths.
interface cbz_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cbz_pkg::COORD_W-1:0]   start_x;
  logic signed [cbz_pkg::COORD_W-1:0]   start_y;
  logic signed [cbz_pkg::COORD_W-1:0]   ctrl1_x;
  logic signed [cbz_pkg::COORD_W-1:0]   ctrl1_y;
  logic signed [cbz_pkg::COORD_W-1:0]   ctrl2_x;
  logic signed [cbz_pkg::COORD_W-1:0]   ctrl2_y;
  logic signed [cbz_pkg::COORD_W-1:0]   end_x;
  logic signed [cbz_pkg::COORD_W-1:0]   end_y;
  logic        [cbz_pkg::CNT_W-1:0]     point_count;
  modport source(output valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                 end_x, end_y, point_count, input ready);
  modport sink(input valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
               end_x, end_y, point_count, output ready);
endinterface

interface cbz_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cbz_pkg::COORD_W-1:0]   curve_x;
  logic signed [cbz_pkg::COORD_W-1:0]   curve_y;
  logic                                 last_point;
  modport source(output valid, curve_x, curve_y, last_point, input ready);
  modport sink(input valid, curve_x, curve_y, last_point, output ready);
endinterface

FILE: rtl/cbz_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: 2^(TFRAC+1) / divisor.
// Depends on cbz_pkg.
module cbz_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cbz_pkg::DVS_W-1:0]     divisor,
  output logic                          done,
  output logic [cbz_pkg::DIV_W-1:0]     quo,
  output logic [cbz_pkg::DVS_W-1:0]     rem
);
  import cbz_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_W + 1);

  logic                 busy_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic [DIV_W-1:0]     dd_r;
  logic [DIV_W-1:0]     q_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     dvs_r;
  logic                 done_r;
  logic [DVS_W:0]       shifted;
  logic                 fits;

  assign shifted = {rem_r, dd_r[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(DIV_W);
        dd_r   <= DIV_W'(1) << (DIV_W - 1);
        q_r    <= '0;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        // shift in one dividend bit, subtract when it fits
        rem_r <= fits ? DVS_W'(shifted - {1'b0, dvs_r}) : shifted[DVS_W-1:0];
        q_r   <= {q_r[DIV_W-2:0], fits};
        dd_r  <= {dd_r[DIV_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/cubic_bezier_point_generator.sv
`timescale 1ns / 1ps
// Cubic Bezier point generator: N points per curve, Horner on one shared multiplier.
// Setup on accept, plus a step division when N > 1. Each point then alternates multiply
// and round/add steps through the x then y Horner terms, then an output step that waits
// on out ready. One curve at a time; ready only when idle. Synchronous active-low reset
// clears the sequencer and the output valid; payload registers are not reset.
module cubic_bezier_point_generator (
  input  logic      clk,
  input  logic      rst_n,
  cbz_in_if.sink    in_ch,
  cbz_out_if.source out_ch
);
  import cbz_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_ADD, S_EMIT} state_t;

  state_t                     state_r, state_nxt;
  logic                       axis_r, axis_nxt;
  logic [1:0]                 step_r, step_nxt;
  logic [IDX_W-1:0]           idx_r, idx_nxt;
  logic [CNT_W-1:0]           n_r, n_nxt;
  logic [DVS_W-1:0]           dv_r, dv_nxt;
  logic [T_W-1:0]             q0_r, q0_nxt;
  logic [DVS_W-1:0]           r0_r, r0_nxt;
  logic [DVS_W-1:0]           racc_r, racc_nxt;
  logic [T_W-1:0]             t_r, t_nxt;
  logic signed [HORN_W-1:0]   h_r, h_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [COEF_W-1:0]   a_r [2];
  logic signed [COEF_W-1:0]   b_r [2];
  logic signed [COEF_W-1:0]   c_r [2];
  logic signed [COORD_W-1:0]  p0_r [2];
  logic signed [COORD_W-1:0]  resx_r, resy_r;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [COORD_W-1:0]  out_x_r, out_y_r;
  logic                       out_last_r;

  logic                       div_start, div_done;
  logic [DIV_W-1:0]           div_quo;
  logic [DVS_W-1:0]           div_rem;

  logic                       accept, load_coef, emit_go, is_last;
  logic [CNT_W-1:0]           n_sat;
  logic signed [COEF_W-1:0]   ca [2], cb [2], cc [2];
  logic signed [COORD_W-1:0]  cp0 [2];
  logic signed [PROD_W:0]     prod_rnd;
  logic signed [HORN_W-1:0]   prod_sh, addend, h_sum;
  logic [DVS_W:0]             rsum;
  logic [T_W:0]               t_inc;

  assign accept = in_ch.valid && in_ch.ready;
  assign n_sat  = (in_ch.point_count > CNT_W'(MAX_PTS)) ? CNT_W'(MAX_PTS)
                                                        : in_ch.point_count;

  // per-axis coefficients from the control points
  always_comb begin
    logic signed [COEF_W-1:0] p0, p1, p2, p3;
    logic signed [COEF_W-1:0] d10, d21;
    for (int k = 0; k < 2; k++) begin
      p0 = COEF_W'(k == 0 ? in_ch.start_x : in_ch.start_y);
      p1 = COEF_W'(k == 0 ? in_ch.ctrl1_x : in_ch.ctrl1_y);
      p2 = COEF_W'(k == 0 ? in_ch.ctrl2_x : in_ch.ctrl2_y);
      p3 = COEF_W'(k == 0 ? in_ch.end_x : in_ch.end_y);
      d10 = p1 - p0;
      d21 = p2 - p1;
      cc[k]  = (d10 <<< 1) + d10;
      cb[k]  = (d21 <<< 1) + d21 - cc[k];
      ca[k]  = p3 - p0 - cc[k] - cb[k];
      cp0[k] = k == 0 ? in_ch.start_x : in_ch.start_y;
    end
  end

  cbz_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (dv_nxt),
    .done    (div_done),
    .quo     (div_quo),
    .rem     (div_rem)
  );

  // round-half-up shift of the product, then add the next Horner term
  assign prod_rnd = PROD_W'(prod_r) + (PROD_W+1)'(1 << (TFRAC - 1));
  assign prod_sh  = prod_rnd[TFRAC+HORN_W-1:TFRAC];
  always_comb begin
    case (step_r)
      2'd0:    addend = HORN_W'(b_r[axis_r]);
      2'd1:    addend = HORN_W'(c_r[axis_r]);
      default: addend = HORN_W'(p0_r[axis_r]);
    endcase
  end
  assign h_sum = prod_sh + addend;

  assign is_last = {1'b0, idx_r} == n_r - 1'b1;
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign rsum    = {1'b0, racc_r} + {1'b0, r0_r};

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    dv_nxt        = dv_r;
    q0_nxt        = q0_r;
    r0_nxt        = r0_r;
    racc_nxt      = racc_r;
    t_nxt         = t_r;
    h_nxt         = h_r;
    prod_nxt      = prod_r;
    div_start     = 1'b0;
    load_coef     = 1'b0;
    t_inc         = '0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          load_coef = 1'b0;
          n_nxt     = n_sat;
          dv_nxt    = DVS_W'({n_sat - 1'b1, 1'b0});
          idx_nxt   = '0;
          t_nxt     = '0;
          axis_nxt  = 1'b0;
          step_nxt  = 2'd0;
          h_nxt     = HORN_W'(ca[0]);
          if (n_sat == CNT_W'(1)) begin
            state_nxt = S_MUL;
          end else if (n_sat != '0) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          q0_nxt    = T_W'(div_quo);
          r0_nxt    = div_rem;
          racc_nxt  = DVS_W'(dv_r >> 1);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(h_r) * PROD_W'($signed({1'b0, t_r}));
        state_nxt = S_ADD;
      end
      S_ADD: begin
        state_nxt = S_MUL;
        h_nxt     = h_sum;
        step_nxt  = step_r + 1'b1;
        if (step_r == 2'd2) begin
          step_nxt = 2'd0;
          if (!axis_r) begin
            axis_nxt = 1'b1;
            h_nxt    = HORN_W'(a_r[1]);
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            // advance t by the stepped quotient, carrying the remainder
            idx_nxt  = idx_r + 1'b1;
            axis_nxt = 1'b0;
            h_nxt    = HORN_W'(a_r[0]);
            if (rsum >= {1'b0, dv_r}) begin
              racc_nxt = DVS_W'(rsum - {1'b0, dv_r});
              t_inc    = {1'b0, t_r} + {1'b0, q0_r} + 1'b1;
            end else begin
              racc_nxt = rsum[DVS_W-1:0];
              t_inc    = {1'b0, t_r} + {1'b0, q0_r};
            end
            t_nxt     = t_inc[T_W-1:0];
            state_nxt = S_MUL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      axis_r      <= 1'b0;
      step_r      <= 2'd0;
      idx_r       <= '0;
      n_r         <= '0;
      t_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      axis_r      <= axis_nxt;
      step_r      <= step_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      dv_r        <= dv_nxt;
      q0_r        <= q0_nxt;
      r0_r        <= r0_nxt;
      racc_r      <= racc_nxt;
      t_r         <= t_nxt;
      h_r         <= h_nxt;
      prod_r      <= prod_nxt;
      if (accept) begin
        for (int k = 0; k < 2; k++) begin
          a_r[k]  <= ca[k];
          b_r[k]  <= cb[k];
          c_r[k]  <= cc[k];
          p0_r[k] <= cp0[k];
        end
      end
      if (state_r == S_ADD && step_r == 2'd2) begin
        if (!axis_r) resx_r <= sat_coord(h_sum);
        else         resy_r <= sat_coord(h_sum);
      end
      if (emit_go) begin
        out_x_r    <= resx_r;
        out_y_r    <= resy_r;
        out_last_r <= is_last;
      end
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE) && !load_coef;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.curve_x    = out_x_r;
  assign out_ch.curve_y    = out_y_r;
  assign out_ch.last_point = out_last_r;

  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    t_r <= T_W'(1 << TFRAC))
    else $error("t beyond 1.0");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_ADD || state_r == S_EMIT) |-> ({1'b0, idx_r} < n_r))
    else $error("point index past count");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && n_r > CNT_W'(1)) |-> (racc_r < dv_r))
    else $error("step remainder not reduced");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside setup");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && is_last) |=> (state_r == S_IDLE && out_ch.last_point))
    else $error("last point not followed by idle");

endmodule
